FILE: src/pba_pkg.sv
package pba_pkg;

	// Pages held in one word of the bitmap memory.
	localparam int WORD_BITS = 16;
	localparam int BIT_W     = 4;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_RUN   = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [8:0] run_length;
		logic [7:0] page_index;
	} pba_req_t;

	typedef struct packed {
		logic       status;
		logic [7:0] first_page;
	} pba_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_MARK_FIRST,
		ST_MARK,
		ST_FREE_WR,
		ST_RESP
	} pba_state_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic eval;
		logic mark_rd;
		logic mark_wr;
		logic free_rd;
		logic free_wr;
		logic res_fail;
		logic res_alloc;
		logic res_free;
	} pba_cmd_t;

	typedef struct packed {
		logic want_alloc;
		logic free_ok;
		logic hit;
		logic scan_last;
		logic mark_last;
	} pba_sts_t;

endpackage

FILE: src/pba_ctrl.sv
module pba_ctrl import pba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  pba_sts_t sts,
	output pba_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	pba_state_t state_q;
	pba_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.want_alloc) begin
					state_d = ST_SCAN;
				end else if (sts.free_ok) begin
					state_d = ST_FREE_WR;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					state_d = ST_MARK_FIRST;
				end else if (sts.scan_last) begin
					state_d = ST_RESP;
				end
			end
			ST_MARK_FIRST: state_d = ST_MARK;
			ST_MARK: begin
				if (sts.mark_last) begin
					state_d = ST_RESP;
				end
			end
			ST_FREE_WR: state_d = ST_RESP;
			ST_RESP:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_RESP);
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_DECODE: begin
				if (sts.want_alloc) begin
					cmd.scan_rd = 1'b1;
				end else if (sts.free_ok) begin
					cmd.free_rd = 1'b1;
				end else begin
					cmd.res_fail = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.eval = 1'b1;
				if (!sts.hit) begin
					if (sts.scan_last) begin
						cmd.res_fail = 1'b1;
					end else begin
						cmd.scan_rd = 1'b1;
					end
				end
			end
			ST_MARK_FIRST: begin
				cmd.mark_rd = 1'b1;
			end
			ST_MARK: begin
				cmd.mark_wr = 1'b1;
				if (sts.mark_last) begin
					cmd.res_alloc = 1'b1;
				end else begin
					cmd.mark_rd = 1'b1;
				end
			end
			ST_FREE_WR: begin
				cmd.free_wr  = 1'b1;
				cmd.res_free = 1'b1;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/pba_datapath.sv
module pba_datapath import pba_pkg::*; #(
	parameter int POOL_PAGES     = 256,
	parameter int RESERVED_PAGES = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  pba_req_t req,
	input  pba_cmd_t cmd,
	output pba_sts_t sts,
	output pba_rsp_t rsp
);

	localparam int NUM_WORDS = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PG_W      = WA_W + BIT_W;
	localparam int CNT_W     = $clog2(POOL_PAGES + 1);
	localparam int M1_W      = (CNT_W > PG_W) ? CNT_W : PG_W;
	localparam int CMP_W     = ((M1_W > 9) ? M1_W : 9) + 1;
	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);
	localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

	// Bitmap storage; a word never written reads as its reset contents.
	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] wvalid_q;

	logic [WORD_BITS-1:0] rd_data_s1;
	logic [WA_W-1:0]      rd_word_s1;
	logic                 rd_valid_s1;

	pba_req_t        req_q;
	logic [8:0]      len_q;
	logic [WA_W-1:0] scan_ptr_q;
	logic [WA_W-1:0] mark_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PG_W-1:0] start_q;
	logic [PG_W-1:0] end_q;
	pba_rsp_t        res_q;

	logic [WORD_BITS-1:0] eff_word;
	logic [WORD_BITS-1:0] excl_word;
	logic [WORD_BITS-1:0] free_v;
	logic [CMP_W-1:0]     run_v [WORD_BITS];
	logic [CMP_W-1:0]     len_ext;
	logic                 hit;
	logic [BIT_W-1:0]     hit_bit;
	logic [PG_W-1:0]      end_page;
	logic [PG_W-1:0]      start_page;
	logic [WORD_BITS-1:0] mark_mask;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WA_W-1:0]      pg_word;
	logic [BIT_W-1:0]     pg_bit;
	logic [WA_W-1:0]      rd_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_data;

	function automatic logic [WORD_BITS-1:0] init_word(input logic [WA_W-1:0] w);
		logic [WORD_BITS-1:0] v;
		v = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			v[b] = ({w, BIT_W'(b)} < RESERVED_PAGES);
		end
		return v;
	endfunction

	function automatic logic [WORD_BITS-1:0] excl_of(input logic [WA_W-1:0] w);
		logic [WORD_BITS-1:0] v;
		v = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			v[b] = ({w, BIT_W'(b)} < RESERVED_PAGES) || ({w, BIT_W'(b)} >= POOL_PAGES);
		end
		return v;
	endfunction

	assign eff_word  = rd_valid_s1 ? rd_data_s1 : init_word(rd_word_s1);
	assign excl_word = excl_of(rd_word_s1);
	assign free_v    = ~(eff_word | excl_word);
	assign len_ext   = CMP_W'(len_q);

	// Length of the free run that ends at each bit, counting the run carried
	// in from earlier words when no used bit lies below it in this word.
	always_comb begin
		logic             found;
		logic [BIT_W-1:0] lastu;
		for (int b = 0; b < WORD_BITS; b++) begin
			found = 1'b0;
			lastu = '0;
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j <= b && !free_v[j]) begin
					found = 1'b1;
					lastu = BIT_W'(j);
				end
			end
			if (!free_v[b]) begin
				run_v[b] = '0;
			end else if (found) begin
				run_v[b] = CMP_W'(b) - CMP_W'(lastu);
			end else begin
				run_v[b] = CMP_W'(cnt_q) + CMP_W'(b + 1);
			end
		end
	end

	always_comb begin
		hit     = 1'b0;
		hit_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_v[b] && run_v[b] == len_ext) begin
				hit     = 1'b1;
				hit_bit = BIT_W'(b);
			end
		end
	end

	assign end_page   = {rd_word_s1, hit_bit};
	assign start_page = PG_W'(CMP_W'(end_page) + CMP_W'(1) - len_ext);

	assign lo_mask = (rd_word_s1 == start_q[PG_W-1:BIT_W]) ?
		(ONES << start_q[BIT_W-1:0]) : ONES;
	assign hi_mask = (rd_word_s1 == end_q[PG_W-1:BIT_W]) ?
		(ONES >> (BIT_W'(WORD_BITS - 1) - end_q[BIT_W-1:0])) : ONES;
	assign mark_mask = lo_mask & hi_mask;

	assign pg_word = WA_W'(req_q.page_index[7:BIT_W]);
	assign pg_bit  = req_q.page_index[BIT_W-1:0];

	always_comb begin
		rd_addr = scan_ptr_q;
		if (cmd.mark_rd) begin
			rd_addr = mark_ptr_q;
		end else if (cmd.free_rd) begin
			rd_addr = pg_word;
		end
	end

	assign rd_en   = cmd.scan_rd | cmd.mark_rd | cmd.free_rd;
	assign wr_en   = cmd.mark_wr | cmd.free_wr;
	assign wr_data = cmd.mark_wr ? (eff_word | mark_mask) :
		(eff_word & ~(WORD_BITS'(1) << pg_bit));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[rd_word_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_word_s1  <= '0;
		end else begin
			if (wr_en) begin
				wvalid_q[rd_word_s1] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= wvalid_q[rd_addr];
				rd_word_s1  <= rd_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req;
			len_q      <= (req.req_type == REQ_ALLOC) ? 9'd1 : req.run_length;
			scan_ptr_q <= '0;
			cnt_q      <= '0;
		end
		if (cmd.scan_rd && scan_ptr_q != LAST_WORD) begin
			scan_ptr_q <= scan_ptr_q + WA_W'(1);
		end
		if (cmd.eval) begin
			cnt_q <= CNT_W'(run_v[WORD_BITS-1]);
			if (hit) begin
				start_q    <= start_page;
				end_q      <= end_page;
				mark_ptr_q <= start_page[PG_W-1:BIT_W];
			end
		end
		if (cmd.mark_rd && mark_ptr_q != LAST_WORD) begin
			mark_ptr_q <= mark_ptr_q + WA_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cmd.res_fail) begin
			res_q <= '{status: 1'b1, first_page: 8'd0};
		end else if (cmd.res_alloc) begin
			res_q <= '{status: 1'b0, first_page: 8'(start_q)};
		end else if (cmd.res_free) begin
			res_q <= '{status: 1'b0, first_page: 8'd0};
		end
	end

	assign sts.want_alloc = (req_q.req_type == REQ_ALLOC) ||
		(req_q.req_type == REQ_RUN && req_q.run_length != 9'd0);
	assign sts.free_ok    = (req_q.req_type == REQ_FREE) &&
		(CMP_W'(req_q.page_index) < CMP_W'(POOL_PAGES));
	assign sts.hit        = hit;
	assign sts.scan_last  = (rd_word_s1 == LAST_WORD);
	assign sts.mark_last  = (rd_word_s1 == end_q[PG_W-1:BIT_W]);

	assign rsp = res_q;

endmodule

FILE: src/page_bitmap_allocator_core.sv
// Channel   Handshake      Payload     Direction
// request   start / busy   req         in, taken when start is high and busy low
// result    done           rsp         out, one cycle per beat, cannot be stalled
//
// Each request occupies the block from its accept edge until the cycle after done.
// A free reads its bitmap word and writes it back; an allocation scans the 16-page words
// in order until a run fits, then marks each word that the run covers (a failed search
// stops after the last word). Scan and mark use the bitmap memory's single read port,
// one word per cycle. busy stays high through the result beat.
// Reset is asynchronous and active low; no sweep of the bitmap follows it.
module page_bitmap_allocator_core import pba_pkg::*; #(
	parameter int POOL_PAGES     = 256,
	parameter int RESERVED_PAGES = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pba_req_t req,
	output logic     done,
	output pba_rsp_t rsp
);

	pba_cmd_t cmd;
	pba_sts_t sts;

	pba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pba_datapath #(
		.POOL_PAGES     (POOL_PAGES),
		.RESERVED_PAGES (RESERVED_PAGES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: src/pba_checker.sv
module pba_port_checker import pba_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input pba_req_t req,
	input logic     done,
	input pba_rsp_t rsp
);

	// A result beat only appears while a request is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat without a request in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request not held busy");

	// The block is free again right after the result beat.
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block not released after result beat");

	a_fail_page: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status |-> rsp.first_page == 8'd0)
		else $error("failed request reports a nonzero page");

	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown(req))
		else $error("request beat accepted with unknown payload");

endmodule

bind page_bitmap_allocator_core pba_port_checker u_pba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

FILE: bench/pba_checker.sv
module pba_checker import pba_pkg::*; #(
	parameter int POOL_PAGES     = 256,
	parameter int RESERVED_PAGES = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  pba_req_t req,
	input  logic     done,
	input  pba_rsp_t rsp,
	output int       fail_count,
	output int       outstanding
);

	logic     page_taken [POOL_PAGES];
	pba_rsp_t grant_q [$];
	pba_rsp_t want;
	int       mismatches;

	// First fit above the reserved pages; the whole run is marked on success.
	function automatic bit claim_run(input int unsigned len, output int unsigned first);
		int unsigned count;
		int unsigned base;
		count = 0;
		base  = 0;
		first = 0;
		if (len == 0)
			return 1'b0;
		for (int unsigned i = RESERVED_PAGES; i < POOL_PAGES; i++) begin
			if (page_taken[i]) begin
				count = 0;
			end else begin
				if (count == 0)
					base = i;
				count++;
				if (count == len) begin
					for (int unsigned j = base; j <= i; j++)
						page_taken[j] = 1'b1;
					first = base;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic pba_rsp_t predict_grant(input pba_req_t r);
		pba_rsp_t    g;
		int unsigned first;
		g.status     = 1'b1;
		g.first_page = 8'd0;
		case (r.req_type)
			REQ_ALLOC: begin
				if (claim_run(1, first)) begin
					g.status     = 1'b0;
					g.first_page = first[7:0];
				end
			end
			REQ_RUN: begin
				if (claim_run(32'(r.run_length), first)) begin
					g.status     = 1'b0;
					g.first_page = first[7:0];
				end
			end
			REQ_FREE: begin
				if (r.page_index < POOL_PAGES) begin
					page_taken[r.page_index] = 1'b0;
					g.status = 1'b0;
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_PAGES; i++)
				page_taken[i] = (i < RESERVED_PAGES);
			grant_q.delete();
			mismatches = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// The result beat is checked before a request taken at the same edge is queued.
			if (done) begin
				if (grant_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none, got status %0d page %0d",
						$time, rsp.status, rsp.first_page);
				end else begin
					want = grant_q.pop_front();
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.first_page !== want.first_page) begin
						mismatches++;
						$display("%0t: first_page expected %0d, got %0d",
							$time, want.first_page, rsp.first_page);
					end
				end
			end
			if (start && !busy)
				grant_q.push_back(predict_grant(req));
			fail_count  <= mismatches;
			outstanding <= grant_q.size();
		end
	end

endmodule

FILE: bench/tb_page_bitmap_allocator_core.sv
module tb_page_bitmap_allocator_core;
	import pba_pkg::*;

	localparam int POOL_PAGES     = 256;
	localparam int RESERVED_PAGES = 3;
	localparam int TOTAL_ITEMS    = 520;
	// Request code that the block does not use; it must be answered with a failure.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	pba_req_t req    = '0;
	logic     busy;
	logic     done;
	pba_rsp_t rsp;
	int       fail_count;
	int       outstanding;
	bit       no_gaps = 1'b0;
	int       sent    = 0;

	always #2 clk = ~clk;

	page_bitmap_allocator_core #(
		.POOL_PAGES    (POOL_PAGES),
		.RESERVED_PAGES(RESERVED_PAGES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	pba_checker #(
		.POOL_PAGES    (POOL_PAGES),
		.RESERVED_PAGES(RESERVED_PAGES)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		#(400_000 * 4);
		$display("Mismatches found");
		$finish;
	end

	// Drives one request beat and returns at the edge that accepts it; start stays high
	// so that a request with no gap is taken as soon as the block is idle again.
	task automatic issue(input logic [1:0] kind, input logic [8:0] len, input logic [7:0] page);
		pba_req_t r;
		int       gap;
		r.req_type   = kind;
		r.run_length = len;
		r.page_index = page;
		if ($urandom_range(0, 29) == 0)
			no_gaps = !no_gaps;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	initial begin
		int         base;
		int         cnt;
		int         roll;
		logic [8:0] len;
		bit         paused;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(REQ_ALLOC, 9'h1FF, 8'hFF);
		issue(REQ_RUN, 9'd0, 8'h00);
		issue(REQ_RUN, 9'd1, 8'($urandom));
		issue(REQ_RUN, 9'd256, 8'($urandom));
		issue(REQ_RUN, 9'h1FF, 8'($urandom));
		// Releasing a reserved page must not make it allocatable.
		issue(REQ_FREE, 9'($urandom), 8'd0);
		issue(REQ_ALLOC, 9'd0, 8'd0);
		issue(REQ_FREE, 9'h1FF, 8'd3);
		issue(REQ_FREE, 9'd0, 8'd3);
		issue(REQ_RUN, 9'd4, 8'($urandom));
		issue(REQ_ALLOC, 9'($urandom), 8'($urandom));
		issue(REQ_FREE, 9'h1FF, 8'd255);
		issue(REQ_UNUSED, 9'h1FF, 8'hFF);
		issue(REQ_UNUSED, 9'd0, 8'd0);
		// Takes everything that is left, so the pool is full afterwards.
		issue(REQ_RUN, 9'd246, 8'($urandom));
		issue(REQ_ALLOC, 9'($urandom), 8'($urandom));
		issue(REQ_RUN, 9'd1, 8'($urandom));
		issue(REQ_FREE, 9'($urandom), 8'd255);
		issue(REQ_FREE, 9'($urandom), 8'd128);
		issue(REQ_RUN, 9'd2, 8'($urandom));
		issue(REQ_FREE, 9'($urandom), 8'd127);
		issue(REQ_RUN, 9'd2, 8'($urandom));
		issue(REQ_ALLOC, 9'($urandom), 8'($urandom));
		issue(REQ_ALLOC, 9'($urandom), 8'($urandom));

		while (sent < TOTAL_ITEMS) begin
			if (!paused && sent >= TOTAL_ITEMS / 2) begin
				paused = 1'b1;
				start <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				// A block of neighboring frees opens room for the longer runs.
				base = $urandom_range(0, POOL_PAGES - 1);
				cnt  = $urandom_range(4, 40);
				for (int k = 0; k < cnt && base + k < POOL_PAGES && sent < TOTAL_ITEMS; k++)
					issue(REQ_FREE, 9'($urandom), 8'(base + k));
			end else if (roll < 40) begin
				issue(REQ_ALLOC, 9'($urandom), 8'($urandom));
			end else if (roll < 70) begin
				roll = $urandom_range(0, 19);
				if (roll == 0)
					len = 9'd0;
				else if (roll < 15)
					len = 9'($urandom_range(1, 8));
				else if (roll < 18)
					len = 9'($urandom_range(9, 64));
				else
					len = 9'($urandom_range(0, 511));
				issue(REQ_RUN, len, 8'($urandom));
			end else if (roll < 97) begin
				issue(REQ_FREE, 9'($urandom), 8'($urandom));
			end else begin
				issue(REQ_UNUSED, 9'($urandom), 8'($urandom));
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
